### design/tscc_pkg.sv
`default_nettype none
package tscc_pkg;

   // Depth of the per-id store; kept a power of two so the id folds by bit slicing
   localparam int PID_COUNT = 8192;
   localparam int PID_AW    = $clog2(PID_COUNT);

   localparam logic [3:0]  CC_MASK     = 4'h0F;
   localparam logic [12:0] PID_PAT     = 13'h0000;
   localparam logic [12:0] PID_CAT     = 13'h0001;
   localparam logic [12:0] PID_TSDT    = 13'h0002;
   localparam logic [12:0] PID_NIT     = 13'h0010;
   localparam logic [12:0] PID_SDT     = 13'h0011;
   localparam logic [12:0] PID_NULL    = 13'h1FFF;

   typedef enum logic [2:0] {
      V_IGNORED   = 3'd0,
      V_IN_ORDER  = 3'd1,
      V_FIRST     = 3'd2,
      V_DUPLICATE = 3'd3,
      V_BREAK     = 3'd4
   } verdict_type;

   typedef enum logic [1:0] {
      CLS_UNKNOWN = 2'd0,
      CLS_PROGRAM = 2'd1,
      CLS_PES     = 2'd2,
      CLS_SECTION = 2'd3
   } class_type;

   typedef enum logic [1:0] {
      ROUTE_NONE    = 2'd0,
      ROUTE_PROGRAM = 2'd1,
      ROUTE_PES     = 2'd2,
      ROUTE_SECTION = 2'd3
   } route_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   // One entry of the per-id store
   typedef struct packed {
      logic       valid;
      logic       dup;
      logic [3:0] last;
   } entry_type;

   // One header word as held during its lookup
   typedef struct packed {
      logic [12:0] pid;
      logic [3:0]  cc;
      logic        has_payload;
      logic        disc_flag;
      logic [1:0]  pid_class;
      logic        tables_complete;
   } item_type;

   // Outcome of the update stage
   typedef struct packed {
      logic        we;
      entry_type   wr_entry;
      verdict_type verdict;
      logic        discard;
      route_type   route;
   } upd_type;

endpackage
`default_nettype wire

### design/ts_continuity_checker.sv
// Transport stream continuity counter checker.
// Input channel (req_*): one parsed packet header per word, valid/ready handshake.
// Result channel (rsp_*): one verdict word per header, in order, valid/ready handshake.
// Each header reads its id's entry (last counter, duplicate mark, valid) from one
// synchronous store, updates it and, unless the id is ignored, writes it back as the
// lookup finishes. The header and the store read are registered on accept; the result
// register is loaded when the lookup finishes, and rsp_valid is high from then.
// A header is taken only in the idle state: its store entry is read, then written
// back, and the next header is taken only after that lookup has finished.
// The result sits in an output register, so a new header is taken while it waits;
// if the receiver stalls, the lookup stage holds until the register frees.
// Reset: synchronous, active high. After reset a clearing pass writes every entry
// of the store to zero, one entry per cycle (PID_COUNT entries, 8192 by default);
// req_ready stays low during that pass.
`default_nettype none
module ts_continuity_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [12:0] req_pid,
   input  wire logic [3:0]  req_cc,
   input  wire logic        req_has_payload,
   input  wire logic        req_disc_flag,
   input  wire logic [1:0]  req_pid_class,
   input  wire logic        req_tables_complete,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [2:0]  rsp_verdict,
   output logic             rsp_discard_partial,
   output logic      [1:0]  rsp_route
);

   localparam int AW = tscc_pkg::PID_AW;
   localparam int EW = $bits(tscc_pkg::entry_type);

   tscc_pkg::state_type state_ff, state_in;
   logic [AW-1:0]       clr_cnt_ff, clr_cnt_in;
   tscc_pkg::item_type  item_ff, item_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          verdict_ff, verdict_in;
   logic                discard_ff, discard_in;
   logic [1:0]          route_ff, route_in;

   logic                accept;
   logic                out_free;
   logic                finish;
   logic                clearing;
   logic                clr_last;
   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [EW-1:0]       ram_wdata;
   logic [EW-1:0]       ram_rdata;
   tscc_pkg::upd_type   upd;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign clr_last = (clr_cnt_ff == AW'(tscc_pkg::PID_COUNT - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tscc_pkg::ST_CLEAR:  if (clr_last) state_in = tscc_pkg::ST_IDLE;
         tscc_pkg::ST_IDLE:   if (accept) state_in = tscc_pkg::ST_LOOKUP;
         tscc_pkg::ST_LOOKUP: if (out_free) state_in = tscc_pkg::ST_IDLE;
         default:             state_in = tscc_pkg::ST_CLEAR;
      endcase
   end

   // State outputs
   always_comb begin
      req_ready = 1'b0;
      clearing  = 1'b0;
      finish    = 1'b0;
      case (state_ff)
         tscc_pkg::ST_CLEAR:  clearing  = 1'b1;
         tscc_pkg::ST_IDLE:   req_ready = 1'b1;
         tscc_pkg::ST_LOOKUP: finish    = out_free;
         default:             clearing  = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tscc_pkg::ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Advance the clearing address
   assign clr_cnt_in = clearing ? clr_cnt_ff + AW'(1) : clr_cnt_ff;

   // Capture the header word on accept
   always_comb begin
      item_in = item_ff;
      if (accept) begin
         item_in.pid             = req_pid;
         item_in.cc              = req_cc;
         item_in.has_payload     = req_has_payload;
         item_in.disc_flag       = req_disc_flag;
         item_in.pid_class       = req_pid_class;
         item_in.tables_complete = req_tables_complete;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   // Store write: clearing pass or write-back of the updated entry
   always_comb begin
      if (clearing) begin
         ram_we    = 1'b1;
         ram_waddr = clr_cnt_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = finish && upd.we;
         ram_waddr = item_ff.pid[AW-1:0];
         ram_wdata = upd.wr_entry;
      end
   end

   tscc_ram #(
      .WIDTH (EW),
      .DEPTH (tscc_pkg::PID_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (req_pid[AW-1:0]),
      .rd_data (ram_rdata)
   );

   tscc_update u_update (
      .item  (item_ff),
      .entry (tscc_pkg::entry_type'(ram_rdata)),
      .upd   (upd)
   );

   // Load the result register, drop valid once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      verdict_in   = verdict_ff;
      discard_in   = discard_ff;
      route_in     = route_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         verdict_in   = upd.verdict;
         discard_in   = upd.discard;
         route_in     = upd.route;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
      discard_ff <= discard_in;
      route_ff   <= route_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_verdict         = verdict_ff;
   assign rsp_discard_partial = discard_ff;
   assign rsp_route           = route_ff;

`ifndef SYNTHESIS
   a_no_accept_in_clear : assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_ready)
      else $error("header accepted during clearing pass");

   a_accept_to_lookup : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == tscc_pkg::ST_LOOKUP) && !req_ready)
      else $error("accepted header did not enter lookup");

   a_lookup_waits : assert property (@(posedge clock) disable iff (reset)
      (state_ff == tscc_pkg::ST_LOOKUP) && rsp_valid_ff && !rsp_ready
      |=> state_ff == tscc_pkg::ST_LOOKUP)
      else $error("lookup left while result register was full");

   a_dup_not_routed : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (verdict_ff == tscc_pkg::V_DUPLICATE)
      |-> route_ff == tscc_pkg::ROUTE_NONE)
      else $error("dropped duplicate was routed");

   a_break_discards : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (verdict_ff == tscc_pkg::V_BREAK) |-> discard_ff)
      else $error("continuity break without discard");
`endif

endmodule
`default_nettype wire

### design/tscc_ram.sv
`default_nettype none
module tscc_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port, hold data when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### design/tscc_update.sv
`default_nettype none
module tscc_update (
   input  wire tscc_pkg::item_type  item,
   input  wire tscc_pkg::entry_type entry,
   output tscc_pkg::upd_type        upd
);

   tscc_pkg::class_type   cls;
   tscc_pkg::entry_type   nxt;
   tscc_pkg::verdict_type verdict;
   logic                  discard;
   logic                  drop;
   logic [3:0]            expect_cc;
   tscc_pkg::route_type   route;

   // Classify the id: the PAT id is always a program table, reserved ids are ignored
   always_comb begin
      if (item.pid == tscc_pkg::PID_PAT) begin
         cls = tscc_pkg::CLS_PROGRAM;
      end else if (item.pid inside {tscc_pkg::PID_CAT, tscc_pkg::PID_TSDT,
                                    tscc_pkg::PID_NIT, tscc_pkg::PID_SDT,
                                    tscc_pkg::PID_NULL}) begin
         cls = tscc_pkg::CLS_UNKNOWN;
      end else begin
         cls = tscc_pkg::class_type'(item.pid_class);
      end
   end

   assign expect_cc = (entry.last + 4'd1) & tscc_pkg::CC_MASK;

   // Apply signalled discontinuity, then the counter check on payload words
   always_comb begin
      nxt     = entry;
      verdict = tscc_pkg::V_FIRST;
      discard = 1'b0;
      drop    = 1'b0;
      if (item.disc_flag) begin
         discard   = 1'b1;
         nxt.valid = 1'b0;
         nxt.dup   = 1'b0;
      end
      if (item.has_payload) begin
         if (nxt.valid) begin
            if (item.cc == expect_cc) begin
               nxt.dup = 1'b0;
               verdict = tscc_pkg::V_IN_ORDER;
            end else if (item.cc == entry.last && !nxt.dup) begin
               nxt.dup = 1'b1;
               verdict = tscc_pkg::V_DUPLICATE;
               drop    = 1'b1;
            end else begin
               nxt.dup = 1'b0;
               verdict = tscc_pkg::V_BREAK;
               discard = 1'b1;
            end
         end
         if (!drop) begin
            nxt.valid = 1'b1;
            nxt.last  = item.cc;
         end
      end
   end

   // Pick the downstream parser; a dropped duplicate goes nowhere
   always_comb begin
      case (cls)
         tscc_pkg::CLS_PROGRAM:
            route = item.tables_complete ? tscc_pkg::ROUTE_NONE : tscc_pkg::ROUTE_PROGRAM;
         tscc_pkg::CLS_PES:     route = tscc_pkg::ROUTE_PES;
         tscc_pkg::CLS_SECTION: route = tscc_pkg::ROUTE_SECTION;
         default:               route = tscc_pkg::ROUTE_NONE;
      endcase
      if (drop) begin
         route = tscc_pkg::ROUTE_NONE;
      end
   end

   // Ignored ids leave the store alone
   always_comb begin
      if (cls == tscc_pkg::CLS_UNKNOWN) begin
         upd.we       = 1'b0;
         upd.wr_entry = entry;
         upd.verdict  = tscc_pkg::V_IGNORED;
         upd.discard  = 1'b0;
         upd.route    = tscc_pkg::ROUTE_NONE;
      end else begin
         upd.we       = 1'b1;
         upd.wr_entry = nxt;
         upd.verdict  = verdict;
         upd.discard  = discard;
         upd.route    = route;
      end
   end

endmodule
`default_nettype wire
